/* hdl/bde_pkg.sv */
// Shared types and constants of the button debounce event unit.
`timescale 1ns / 1ps
`default_nettype none
package bde_pkg;

    // Button lanes, in raw_levels bit order
    localparam int NUM_BTN    = 5;
    localparam int BTN_LEFT   = 0;
    localparam int BTN_RIGHT  = 1;
    localparam int BTN_LIGHT  = 2;
    localparam int BTN_HORN   = 3;

    // Payload widths
    localparam int NOW_W   = 32;
    localparam int LEVEL_W = NUM_BTN;
    localparam int CODE_W  = 4;

    typedef logic [CODE_W-1:0] t_code;

    // Event codes
    localparam t_code EV_LEFT_DOWN   = 4'd0;
    localparam t_code EV_LEFT_UP     = 4'd1;
    localparam t_code EV_RIGHT_DOWN  = 4'd2;
    localparam t_code EV_RIGHT_UP    = 4'd3;
    localparam t_code EV_HORN_ON     = 4'd4;
    localparam t_code EV_HORN_OFF    = 4'd5;
    localparam t_code EV_LIGHT_PRESS = 4'd6;
    localparam t_code EV_LIGHT_LONG  = 4'd7;
    localparam t_code EV_HAZARD      = 4'd8;

    // Configuration registers
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    typedef logic [CFG_W-1:0]     t_cfg;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_DEBOUNCE = 2'd0;
    localparam t_cfg_idx REG_LONG     = 2'd1;
    localparam t_cfg_idx REG_HAZARD   = 2'd2;

    localparam t_cfg RST_DEBOUNCE = 16'd20;
    localparam t_cfg RST_LONG     = 16'd1500;
    localparam t_cfg RST_HAZARD   = 16'd2000;

    // Events per tick and event queue sizing
    localparam int MAX_EV    = 5;
    localparam int EVQ_DEPTH = 8;
    localparam int EVQ_AW    = 3;

    typedef logic [2:0]      t_ev_cnt;
    typedef logic [EVQ_AW:0] t_evq_cnt;

    // What one debounce lane reports for the current tick
    typedef struct packed {
        logic settled;  // raw level has held for the debounce time
        logic level;    // raw level of this tick
        logic edge_det; // settled level differs from the accepted one
        logic stable;   // accepted level after this tick
    } t_lane_res;

    typedef struct packed {
        t_code code;
        logic  last;
    } t_event;

endpackage
`default_nettype wire

/* hdl/bde_in_if.sv */
// Tick channel: timestamp and raw button levels.
`timescale 1ns / 1ps
`default_nettype none
interface bde_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_ms;
    logic [4:0]  raw_levels;

    modport source (output valid, output now_ms, output raw_levels, input ready);
    modport sink   (input valid, input now_ms, input raw_levels, output ready);
endinterface
`default_nettype wire

/* hdl/bde_out_if.sv */
// Event channel: event code and end-of-tick mark.
`timescale 1ns / 1ps
`default_nettype none
interface bde_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] event_code;
    logic       last_event;

    modport source (output valid, output event_code, output last_event, input ready);
    modport sink   (input valid, input event_code, input last_event, output ready);
endinterface
`default_nettype wire

/* hdl/bde_lane.sv */
// One debounce lane: settle timer and accepted level of a single button.
`timescale 1ns / 1ps
`default_nettype none
module bde_lane #(
    parameter int TIME_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  logic [TIME_BITS-1:0] i_now,
    input  logic                 i_raw,
    input  bde_pkg::t_cfg        i_debounce,
    output bde_pkg::t_lane_res   o_res
);
    import bde_pkg::*;

    logic                 r_seen;
    logic                 r_stable;
    logic [TIME_BITS-1:0] r_start;
    logic                 w_changed;
    logic [TIME_BITS-1:0] w_start;
    logic [TIME_BITS-1:0] w_elapsed;
    logic                 w_settled;

    // Restart the settle timer on any raw change, then compare the wrapped age
    assign w_changed = i_raw != r_seen;
    assign w_start   = w_changed ? i_now : r_start;
    assign w_elapsed = i_now - w_start;
    assign w_settled = w_elapsed >= TIME_BITS'(i_debounce);

    assign o_res.settled  = w_settled;
    assign o_res.level    = i_raw;
    assign o_res.edge_det = w_settled && (i_raw != r_stable);
    assign o_res.stable   = w_settled ? i_raw : r_stable;

    // Advance lane state on each accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen   <= 1'b0;
            r_stable <= 1'b0;
            r_start  <= '0;
        end else if (i_take) begin
            r_seen   <= i_raw;
            r_stable <= o_res.stable;
            r_start  <= w_start;
        end
    end

endmodule
`default_nettype wire

/* hdl/bde_merge.sv */
// Merge stage: light hold, hazard combo and ordered event list of one tick.
`timescale 1ns / 1ps
`default_nettype none
module bde_merge #(
    parameter int TIME_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  logic [TIME_BITS-1:0] i_now,
    input  bde_pkg::t_lane_res   i_lane [bde_pkg::NUM_BTN],
    input  bde_pkg::t_cfg        i_long_ms,
    input  bde_pkg::t_cfg        i_hazard_ms,
    output bde_pkg::t_code       o_codes [bde_pkg::MAX_EV],
    output bde_pkg::t_ev_cnt     o_cnt
);
    import bde_pkg::*;

    logic                 r_long_fired;
    logic [TIME_BITS-1:0] r_lstart;
    logic                 r_combo_active;
    logic                 r_combo_fired;
    logic [TIME_BITS-1:0] r_cstart;

    logic                 n_long_fired;
    logic [TIME_BITS-1:0] n_lstart;
    logic                 n_combo_active;
    logic                 n_combo_fired;
    logic [TIME_BITS-1:0] n_cstart;

    logic                 w_press_edge;
    logic                 w_rel_edge;
    logic [TIME_BITS-1:0] w_lstart;
    logic                 w_lfired;
    logic                 w_long;
    logic                 w_short;
    logic                 w_both;
    logic [TIME_BITS-1:0] w_cstart;
    logic                 w_hazard;
    logic                 w_flag [MAX_EV];
    t_code                w_code [MAX_EV];

    // Light button: press edge starts the hold timer, a release before a long press is a short press
    assign w_press_edge = i_lane[BTN_LIGHT].edge_det && i_lane[BTN_LIGHT].level;
    assign w_rel_edge   = i_lane[BTN_LIGHT].edge_det && !i_lane[BTN_LIGHT].level;
    assign w_lstart     = w_press_edge ? i_now : r_lstart;
    assign w_lfired     = i_lane[BTN_LIGHT].edge_det ? 1'b0 : r_long_fired;
    assign w_short      = w_rel_edge && !r_long_fired;
    assign w_long       = i_lane[BTN_LIGHT].settled && i_lane[BTN_LIGHT].level && !w_lfired
                          && ((i_now - w_lstart) >= TIME_BITS'(i_long_ms));

    assign n_long_fired = w_long | w_lfired;
    assign n_lstart     = w_rel_edge ? '0 : w_lstart;

    // Hazard combo: both blinkers accepted as pressed for the hold time, once per hold
    assign w_both   = i_lane[BTN_LEFT].stable && i_lane[BTN_RIGHT].stable;
    assign w_cstart = r_combo_active ? r_cstart : i_now;
    assign w_hazard = w_both && !r_combo_fired
                      && ((i_now - w_cstart) >= TIME_BITS'(i_hazard_ms));

    assign n_combo_active = w_both;
    assign n_combo_fired  = w_both && (r_combo_fired || w_hazard);
    assign n_cstart       = w_cstart;

    // Candidate events in output order
    always_comb begin
        w_flag[0] = i_lane[BTN_LEFT].edge_det;
        w_code[0] = i_lane[BTN_LEFT].level ? EV_LEFT_DOWN : EV_LEFT_UP;
        w_flag[1] = i_lane[BTN_RIGHT].edge_det;
        w_code[1] = i_lane[BTN_RIGHT].level ? EV_RIGHT_DOWN : EV_RIGHT_UP;
        w_flag[2] = w_short || w_long;
        w_code[2] = w_long ? EV_LIGHT_LONG : EV_LIGHT_PRESS;
        w_flag[3] = i_lane[BTN_HORN].edge_det;
        w_code[3] = i_lane[BTN_HORN].level ? EV_HORN_ON : EV_HORN_OFF;
        w_flag[4] = w_hazard;
        w_code[4] = EV_HAZARD;
    end

    // Pack the present events to the front of the list
    always_comb begin
        t_ev_cnt cnt;
        cnt = '0;
        for (int k = 0; k < MAX_EV; k++) begin
            o_codes[k] = EV_LEFT_DOWN;
        end
        for (int k = 0; k < MAX_EV; k++) begin
            if (w_flag[k]) begin
                o_codes[cnt] = w_code[k];
                cnt          = cnt + 3'd1;
            end
        end
        o_cnt = cnt;
    end

    // Hold light and combo state between ticks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_fired   <= 1'b0;
            r_lstart       <= '0;
            r_combo_active <= 1'b0;
            r_combo_fired  <= 1'b0;
            r_cstart       <= '0;
        end else if (i_take) begin
            r_long_fired   <= n_long_fired;
            r_lstart       <= n_lstart;
            r_combo_active <= n_combo_active;
            r_combo_fired  <= n_combo_fired;
            r_cstart       <= n_cstart;
        end
    end

endmodule
`default_nettype wire

/* hdl/bde_evq.sv */
// Event queue: takes up to five events of a tick at once, sends one per cycle while o_out is ready.
`timescale 1ns / 1ps
`default_nettype none
module bde_evq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  bde_pkg::t_code    i_codes [bde_pkg::MAX_EV],
    input  bde_pkg::t_ev_cnt  i_cnt,
    output logic              o_room,
    bde_out_if.source         o_out
);
    import bde_pkg::*;

    t_event                r_mem [EVQ_DEPTH];
    logic [EVQ_AW-1:0]     r_wr;
    logic [EVQ_AW-1:0]     r_rd;
    t_evq_cnt              r_cnt;
    t_ev_cnt               w_push_cnt;
    logic                  w_pop;

    assign w_push_cnt       = i_push ? i_cnt : '0;
    assign w_pop            = o_out.valid && o_out.ready;
    assign o_room           = r_cnt <= t_evq_cnt'(EVQ_DEPTH - MAX_EV);
    assign o_out.valid      = r_cnt != '0;
    assign o_out.event_code = r_mem[r_rd].code;
    assign o_out.last_event = r_mem[r_rd].last;

    // Write the tick's events to consecutive slots, marking the final one
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_EV; k++) begin
            if (k < int'(w_push_cnt)) begin
                r_mem[r_wr + EVQ_AW'(k)].code <= i_codes[k];
                r_mem[r_wr + EVQ_AW'(k)].last <= (k == int'(w_push_cnt) - 1);
            end
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + EVQ_AW'(w_push_cnt);
            r_rd  <= r_rd + EVQ_AW'(w_pop);
            r_cnt <= r_cnt + t_evq_cnt'(w_push_cnt) - t_evq_cnt'(w_pop);
        end
    end

endmodule
`default_nettype wire

/* hdl/button_debounce_event_unit_core.sv */
// Top level of the button debounce event unit.
//
//  channel   dir  handshake            payload
//  i_in      in   valid/ready          now_ms[31:0], raw_levels[4:0]
//  o_out     out  valid/ready          event_code[3:0], last_event
//  i_cfg_*   in   i_cfg_we, no wait    i_cfg_idx[1:0], i_cfg_data[15:0]
//
// A tick is evaluated in the cycle of its transfer: five debounce lanes run
// side by side and the merge stage queues zero to five events in one go.
// The event queue sends one event per cycle while o_out is ready, and the tick
// port stays ready while at least five queue slots are free.
// Reset is synchronous, active low; it clears all button state, restores the
// register defaults and empties the queue. A stall on o_out only holds
// the queue head; ticks keep flowing until the queue runs short of room.
`timescale 1ns / 1ps
`default_nettype none
module button_debounce_event_unit_core #(
    parameter int TIME_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    bde_in_if.sink              i_in,
    bde_out_if.source           o_out,
    input  logic                i_cfg_we,
    input  bde_pkg::t_cfg_idx   i_cfg_idx,
    input  bde_pkg::t_cfg       i_cfg_data
);
    import bde_pkg::*;

    t_cfg                 r_debounce;
    t_cfg                 r_long;
    t_cfg                 r_hazard;
    logic                 w_take;
    logic                 w_room;
    logic [TIME_BITS-1:0] w_now;
    t_lane_res            w_lane [NUM_BTN];
    t_code                w_codes [MAX_EV];
    t_ev_cnt              w_cnt;

    assign i_in.ready = w_room;
    assign w_take     = i_in.valid && w_room;
    assign w_now      = TIME_BITS'(i_in.now_ms);

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= RST_DEBOUNCE;
            r_long     <= RST_LONG;
            r_hazard   <= RST_HAZARD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DEBOUNCE: r_debounce <= i_cfg_data;
                REG_LONG:     r_long     <= i_cfg_data;
                REG_HAZARD:   r_hazard   <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    // One debounce lane per button
    for (genvar b = 0; b < NUM_BTN; b++) begin : g_lane
        bde_lane #(
            .TIME_BITS (TIME_BITS)
        ) u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_take     (w_take),
            .i_now      (w_now),
            .i_raw      (i_in.raw_levels[b]),
            .i_debounce (r_debounce),
            .o_res      (w_lane[b])
        );
    end

    bde_merge #(
        .TIME_BITS (TIME_BITS)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (w_take),
        .i_now       (w_now),
        .i_lane      (w_lane),
        .i_long_ms   (r_long),
        .i_hazard_ms (r_hazard),
        .o_codes     (w_codes),
        .o_cnt       (w_cnt)
    );

    bde_evq u_evq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_take),
        .i_codes (w_codes),
        .i_cnt   (w_cnt),
        .o_room  (w_room),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire

/* hdl/bde_chk.sv */
// Port checker of the button debounce event unit and its bind.
`timescale 1ns / 1ps
`default_nettype none
module bde_chk (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input bde_pkg::t_code       i_out_code,
    input logic                 i_out_last
);
    import bde_pkg::*;

    // Queue is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("event output valid after reset");

    // Stalled event holds its payload
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_code)
                                        && $stable(i_out_last))
        else $error("stalled event changed");

    // Hazard is always the final event of its tick
    a_hazard_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_code == EV_HAZARD) |-> i_out_last)
        else $error("hazard event not marked last");

    // Only defined codes leave the block
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_code <= EV_HAZARD))
        else $error("undefined event code");

    // Tick port is ready once out of reset with an empty queue
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !i_out_valid |-> i_in_ready)
        else $error("tick port not ready with empty queue");

endmodule

bind button_debounce_event_unit_core bde_chk u_bde_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_code  (o_out.event_code),
    .i_out_last  (o_out.last_event)
);
`default_nettype wire
